/* src/zoom_about_point_controller_defines.svh */
// assertion macros for the zoom-about-point controller
`ifndef ZOOM_ABOUT_POINT_CONTROLLER_DEFINES_SVH
`define ZOOM_ABOUT_POINT_CONTROLLER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ZAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ZAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/zap_pkg.sv */
// shared types, constants and level functions of the zoom-about-point controller
package zap_pkg;

    localparam int MAX_ZOOM_DEF = 16;

    localparam int OPC_W      = 3;
    localparam int CUR_W      = 16;
    localparam int REQ_W      = 8;
    localparam int LVL_W      = 8;
    localparam int P_W        = LVL_W + 1;
    localparam int OUT_LVL_W  = 6;
    localparam int OFS_W      = 32;
    localparam int VH_W       = 16;
    localparam int CY_W       = 18;
    localparam int DIFF_W     = 33;
    localparam int MAG_W      = 32;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 1;

    localparam logic [VH_W-1:0] VIEW_HEIGHT_RST = 16'd1024;

    localparam logic [OPC_W-1:0] OP_STEP_UP   = 3'd0;
    localparam logic [OPC_W-1:0] OP_STEP_DOWN = 3'd1;
    localparam logic [OPC_W-1:0] OP_DOUBLE    = 3'd2;
    localparam logic [OPC_W-1:0] OP_HALVE     = 3'd3;
    localparam logic [OPC_W-1:0] OP_DIRECT    = 3'd4;

    localparam logic signed [LVL_W-1:0] LVL_ZERO = 0;
    localparam logic signed [LVL_W-1:0] LVL_ONE  = 1;
    localparam logic signed [LVL_W-1:0] LVL_MONE = -1;
    localparam logic signed [LVL_W-1:0] LVL_MTWO = -2;

    typedef struct packed {
        logic load;
        logic level_step;
        logic mult_step;
        logic div_start;
        logic round_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

    // smallest power of two strictly above v
    function automatic logic [P_W-1:0] pow2_above(input logic [P_W-1:0] v);
        logic [P_W-1:0] r;
        r = P_W'(1) << (P_W - 1);
        for (int i = P_W - 2; i >= 0; i--)
        begin
            if ((P_W'(1) << i) > v)
            begin
                r = P_W'(1) << i;
            end
        end
        return r;
    endfunction

    // largest power of two strictly below v, at least one
    function automatic logic [P_W-1:0] pow2_below(input logic [P_W-1:0] v);
        logic [P_W-1:0] r;
        r = P_W'(1);
        for (int i = 0; i < P_W - 1; i++)
        begin
            if ((P_W'(1) << i) < v)
            begin
                r = P_W'(1) << i;
            end
        end
        return r;
    endfunction

    function automatic logic signed [LVL_W-1:0] next_level(
        input logic [OPC_W-1:0]        op,
        input logic signed [LVL_W-1:0] lvl,
        input logic signed [REQ_W-1:0] req,
        input logic signed [LVL_W-1:0] maxz
    );
        logic signed [LVL_W-1:0] res;
        logic [P_W-1:0]          mag;
        logic [P_W-1:0]          mx;
        logic [P_W-1:0]          p;
        res = lvl;
        mag = {1'b0, (lvl[LVL_W-1] ? -lvl : lvl)};
        mx  = {1'b0, maxz};
        p   = '0;
        unique case (op)
            OP_STEP_UP:
            begin
                if (lvl < maxz)
                begin
                    res = lvl + LVL_ONE;
                    if (res == LVL_ZERO || res == LVL_MONE)
                    begin
                        res = LVL_ONE;
                    end
                end
            end
            OP_STEP_DOWN:
            begin
                if (lvl > -maxz)
                begin
                    res = lvl - LVL_ONE;
                    if (res == LVL_ZERO || res == LVL_MONE)
                    begin
                        res = LVL_MTWO;
                    end
                end
            end
            OP_DOUBLE:
            begin
                if (lvl >= maxz)
                begin
                    res = lvl;
                end
                else if (lvl >= LVL_ONE)
                begin
                    p = pow2_above(mag);
                    res = (p < mx) ? LVL_W'(p) : maxz;
                end
                else if (lvl >= LVL_MTWO)
                begin
                    res = LVL_ONE;
                end
                else if (mag > mx)
                begin
                    res = -maxz;
                end
                else
                begin
                    p = pow2_below(mag);
                    res = -LVL_W'(p);
                end
            end
            OP_HALVE:
            begin
                if (lvl <= -maxz)
                begin
                    res = lvl;
                end
                else if (lvl > LVL_ONE)
                begin
                    if (mag > mx)
                    begin
                        res = maxz;
                    end
                    else
                    begin
                        res = LVL_W'(pow2_below(mag));
                    end
                end
                else if (lvl >= LVL_MONE)
                begin
                    res = LVL_MTWO;
                end
                else
                begin
                    p = pow2_above(mag);
                    res = (p < mx) ? -LVL_W'(p) : -maxz;
                end
            end
            OP_DIRECT:
            begin
                if (req > maxz)
                begin
                    res = maxz;
                end
                else if (req < -maxz)
                begin
                    res = -maxz;
                end
                else if (req == LVL_ZERO || req == LVL_MONE)
                begin
                    res = LVL_ONE;
                end
                else
                begin
                    res = req;
                end
            end
            default:
            begin
                res = lvl;
            end
        endcase
        return res;
    endfunction

endpackage

/* src/zap_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module zap_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient,
    output logic             rem_nz
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [DEN_W:0]   partial;
    logic             fits;

    assign partial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = partial >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? DEN_W'(partial - {1'b0, divisor}) : partial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

/* src/zap_level.sv */
// zoom level register, next-level selection and scale factors
module zap_level #(
    parameter int MAX_ZOOM = zap_pkg::MAX_ZOOM_DEF,
    localparam int FACT_W  = $clog2(MAX_ZOOM + 1),
    localparam int FW      = 2 * FACT_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              commit,
    input  logic [zap_pkg::OPC_W-1:0]         opcode,
    input  logic signed [zap_pkg::REQ_W-1:0]  req,
    output logic signed [zap_pkg::LVL_W-1:0]  level_new,
    output logic [FW-1:0]                     mul,
    output logic [FW-1:0]                     div
);

    localparam int LVL_W = zap_pkg::LVL_W;

    logic signed [LVL_W-1:0] level_reg;
    logic signed [LVL_W-1:0] level_next;
    logic signed [LVL_W-1:0] new_reg;
    logic [FW-1:0]           mul_reg;
    logic [FW-1:0]           div_reg;
    logic [FACT_W-1:0]       old_num;
    logic [FACT_W-1:0]       old_den;
    logic [FACT_W-1:0]       new_num;
    logic [FACT_W-1:0]       new_den;

    // magnification part of a level
    function automatic logic [FACT_W-1:0] fnum(input logic signed [LVL_W-1:0] l);
        logic [FACT_W-1:0] r;
        r = l[LVL_W-1] ? FACT_W'(1) : l[FACT_W-1:0];
        return r;
    endfunction

    // reduction part of a level
    function automatic logic [FACT_W-1:0] fden(input logic signed [LVL_W-1:0] l);
        logic signed [LVL_W-1:0] n;
        logic [FACT_W-1:0]       r;
        n = -l;
        r = l[LVL_W-1] ? n[FACT_W-1:0] : FACT_W'(1);
        return r;
    endfunction

    assign level_next = zap_pkg::next_level(opcode, level_reg, req, LVL_W'(MAX_ZOOM));

    assign old_num = fnum(level_reg);
    assign old_den = fden(level_reg);
    assign new_num = fnum(level_next);
    assign new_den = fden(level_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= zap_pkg::LVL_ONE;
        end
        else if (commit)
        begin
            level_reg <= new_reg;
        end
    end

    // ratio fnew/fold as (new_num*old_den)/(new_den*old_num)
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            new_reg <= level_next;
            mul_reg <= FW'(new_num) * FW'(old_den);
            div_reg <= FW'(new_den) * FW'(old_num);
        end
    end

    assign level_new = new_reg;
    assign mul       = mul_reg;
    assign div       = div_reg;

endmodule

/* src/zap_dp.sv */
// datapath: cursor capture, offset re-anchoring, rounding, saturation, result register
module zap_dp #(
    parameter int MAX_ZOOM = zap_pkg::MAX_ZOOM_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  zap_pkg::cmd_t                         cmd,
    output zap_pkg::sts_t                         sts,
    input  logic [zap_pkg::OPC_W-1:0]             opcode,
    input  logic signed [zap_pkg::CUR_W-1:0]      cursor_x,
    input  logic signed [zap_pkg::CUR_W-1:0]      cursor_y,
    input  logic signed [zap_pkg::REQ_W-1:0]      requested_level,
    input  logic                                  cfg_we,
    input  logic [zap_pkg::VH_W-1:0]              cfg_wdata,
    output logic [zap_pkg::OUT_LVL_W-1:0]         zoom_level,
    output logic signed [zap_pkg::OFS_W-1:0]      x_offset,
    output logic signed [zap_pkg::OFS_W-1:0]      y_offset,
    output logic                                  saturated
);

    localparam int FACT_W = $clog2(MAX_ZOOM + 1);
    localparam int FW     = 2 * FACT_W;
    localparam int NUM_W  = zap_pkg::MAG_W + FW;
    localparam int Q_W    = NUM_W + 1;
    localparam int R_W    = NUM_W + 2;
    localparam int OFS_W  = zap_pkg::OFS_W;
    localparam int CUR_W  = zap_pkg::CUR_W;
    localparam int CY_W   = zap_pkg::CY_W;
    localparam int DIFF_W = zap_pkg::DIFF_W;
    localparam int MAG_W  = zap_pkg::MAG_W;

    logic [zap_pkg::VH_W-1:0]          vh_reg;
    logic [zap_pkg::OPC_W-1:0]         op_reg;
    logic [zap_pkg::REQ_W-1:0]         req_reg;
    logic [CUR_W-1:0]                  cx_reg;
    logic [CY_W-1:0]                   cy_reg;
    logic [CY_W-1:0]                   cy_flip;
    logic [OFS_W-1:0]                  px_reg;
    logic [OFS_W-1:0]                  py_reg;
    logic [DIFF_W-1:0]                 diff_x;
    logic [DIFF_W-1:0]                 diff_y;
    logic [DIFF_W-1:0]                 ndiff_x;
    logic [DIFF_W-1:0]                 ndiff_y;
    logic                              negx_reg;
    logic                              negy_reg;
    logic [MAG_W-1:0]                  magx_reg;
    logic [MAG_W-1:0]                  magy_reg;
    logic [NUM_W-1:0]                  prodx_reg;
    logic [NUM_W-1:0]                  prody_reg;
    logic [Q_W-1:0]                    qx_reg;
    logic [Q_W-1:0]                    qy_reg;
    logic [R_W-1:0]                    rx;
    logic [R_W-1:0]                    ry;
    logic [OFS_W:0]                    clip_x;
    logic [OFS_W:0]                    clip_y;
    logic signed [zap_pkg::LVL_W-1:0]  level_new;
    logic [FW-1:0]                     mul;
    logic [FW-1:0]                     div;
    logic                              busy_x;
    logic                              busy_y;
    logic [NUM_W-1:0]                  quo_x;
    logic [NUM_W-1:0]                  quo_y;
    logic                              rnz_x;
    logic                              rnz_y;
    logic [zap_pkg::OUT_LVL_W-1:0]     zl_out_reg;
    logic [OFS_W-1:0]                  x_out_reg;
    logic [OFS_W-1:0]                  y_out_reg;
    logic                              sat_out_reg;

    // returns {clipped, value}
    function automatic logic [OFS_W:0] clip(input logic [R_W-1:0] r);
        logic [R_W-OFS_W:0] top;
        logic [OFS_W:0]     res;
        top = r[R_W-1:OFS_W-1];
        if ((&top) || !(|top))
        begin
            res = {1'b0, r[OFS_W-1:0]};
        end
        else if (r[R_W-1])
        begin
            res = {1'b1, 1'b1, {(OFS_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b1, 1'b0, {(OFS_W-1){1'b1}}};
        end
        return res;
    endfunction

    zap_level #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (cmd.level_step),
        .commit    (cmd.commit),
        .opcode    (op_reg),
        .req       (req_reg),
        .level_new (level_new),
        .mul       (mul),
        .div       (div)
    );

    zap_div #(
        .NUM_W (NUM_W),
        .DEN_W (FW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prodx_reg),
        .divisor  (div),
        .busy     (busy_x),
        .quotient (quo_x),
        .rem_nz   (rnz_x)
    );

    zap_div #(
        .NUM_W (NUM_W),
        .DEN_W (FW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prody_reg),
        .divisor  (div),
        .busy     (busy_y),
        .quotient (quo_y),
        .rem_nz   (rnz_y)
    );

    assign sts.div_busy = busy_x | busy_y;

    // flipped y: view_height - 1 - cursor_y
    assign cy_flip = {{(CY_W-zap_pkg::VH_W){1'b0}}, vh_reg} - CY_W'(1)
                   - {{(CY_W-CUR_W){cursor_y[CUR_W-1]}}, cursor_y};

    assign diff_x  = {{(DIFF_W-CUR_W){cx_reg[CUR_W-1]}}, cx_reg} - {px_reg[OFS_W-1], px_reg};
    assign diff_y  = {{(DIFF_W-CY_W){cy_reg[CY_W-1]}}, cy_reg} - {py_reg[OFS_W-1], py_reg};
    assign ndiff_x = DIFF_W'(0) - diff_x;
    assign ndiff_y = DIFF_W'(0) - diff_y;

    assign rx = {{(R_W-CUR_W){cx_reg[CUR_W-1]}}, cx_reg} - {qx_reg[Q_W-1], qx_reg};
    assign ry = {{(R_W-CY_W){cy_reg[CY_W-1]}}, cy_reg} - {qy_reg[Q_W-1], qy_reg};
    assign clip_x = clip(rx);
    assign clip_y = clip(ry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vh_reg <= zap_pkg::VIEW_HEIGHT_RST;
            px_reg <= '0;
            py_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                vh_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                px_reg <= clip_x[OFS_W-1:0];
                py_reg <= clip_y[OFS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            req_reg <= requested_level;
            cx_reg  <= cursor_x;
            cy_reg  <= cy_flip;
        end
        // the sign of (c - p) * mul is the sign of c - p, mul being positive
        if (cmd.level_step)
        begin
            negx_reg <= diff_x[DIFF_W-1];
            negy_reg <= diff_y[DIFF_W-1];
            magx_reg <= diff_x[DIFF_W-1] ? ndiff_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
            magy_reg <= diff_y[DIFF_W-1] ? ndiff_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
        end
        if (cmd.mult_step)
        begin
            prodx_reg <= NUM_W'(magx_reg) * NUM_W'(mul);
            prody_reg <= NUM_W'(magy_reg) * NUM_W'(mul);
        end
        // ceiling of the signed quotient: truncation already rounds negatives up
        if (cmd.round_step)
        begin
            qx_reg <= negx_reg ? (Q_W'(0) - {1'b0, quo_x}) : ({1'b0, quo_x} + Q_W'(rnz_x));
            qy_reg <= negy_reg ? (Q_W'(0) - {1'b0, quo_y}) : ({1'b0, quo_y} + Q_W'(rnz_y));
        end
        if (cmd.commit)
        begin
            zl_out_reg  <= level_new[zap_pkg::OUT_LVL_W-1:0];
            x_out_reg   <= clip_x[OFS_W-1:0];
            y_out_reg   <= clip_y[OFS_W-1:0];
            sat_out_reg <= clip_x[OFS_W] | clip_y[OFS_W];
        end
    end

    assign zoom_level = zl_out_reg;
    assign x_offset   = x_out_reg;
    assign y_offset   = y_out_reg;
    assign saturated  = sat_out_reg;

endmodule

/* src/zap_ctrl.sv */
// command sequencer and result handshake of the zoom-about-point controller
module zap_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  zap_pkg::sts_t sts,
    output zap_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LEVEL  = 7'b0000010,
        S_MULT   = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_ROUND  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                cmd.level_step = 1'b1;
                state_next     = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult_step = 1'b1;
                state_next    = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold the commit until the result register is free
                if (!out_valid_reg || m_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

endmodule

/* src/zoom_about_point_controller.sv */
// zoom-about-point controller: top level
//
// Commands come in on the s_axis transfer channel: opcode in tuser, cursor point and
// requested level in tdata. Each command yields exactly one result transfer on m_axis:
// the new zoom level, the re-anchored display offset and a saturation flag.
// view_height is written through cfg_we / cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. A command passes through
// the level step, the multiply, the divider start, the division, the rounding step and
// the commit before m_axis_tvalid rises. Two bit-serial dividers (one per axis, run side
// by side) form the ceiling of (c - p) * fnew / fold, one quotient bit per cycle.
// One command is worked on at a time; s_axis_tready is high only between commands.
// A finished result sits in an output register, so the next command is taken while
// it waits; if the receiver still stalls when that command completes, the block
// holds it back until the register is free, and s_axis_tready stays low meanwhile.
// Reset sets the level to one, both offsets to zero and view_height to 1024.
`include "zoom_about_point_controller_defines.svh"

module zoom_about_point_controller #(
    parameter int MAX_ZOOM = zap_pkg::MAX_ZOOM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cursor_x [15:0], cursor_y [31:16], requested_level [39:32]
    input  logic [zap_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode [2:0]
    input  logic [zap_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // zoom_level [5:0], x_offset [37:6], y_offset [69:38], zero [71:70]
    output logic [zap_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // saturated [0]
    output logic [zap_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [zap_pkg::VH_W-1:0]         cfg_wdata
);

    zap_pkg::cmd_t                        cmd;
    zap_pkg::sts_t                        sts;
    logic [zap_pkg::OUT_LVL_W-1:0]        zoom_level;
    logic signed [zap_pkg::OFS_W-1:0]     x_offset;
    logic signed [zap_pkg::OFS_W-1:0]     y_offset;
    logic                                 saturated;

    zap_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    zap_dp #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (s_axis_tuser[zap_pkg::OPC_W-1:0]),
        .cursor_x        (s_axis_tdata[15:0]),
        .cursor_y        (s_axis_tdata[31:16]),
        .requested_level (s_axis_tdata[39:32]),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .zoom_level      (zoom_level),
        .x_offset        (x_offset),
        .y_offset        (y_offset),
        .saturated       (saturated)
    );

    assign m_axis_tdata = {2'b00, y_offset, x_offset, zoom_level};
    assign m_axis_tuser = saturated;

    `ZAP_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, (!m_axis_tvalid || m_axis_tready), "result register overwritten while stalled")
    `ZAP_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, sts.div_busy, "dividers did not start")
    `ZAP_ASSERT_NOW(a_accept_quiet, clk, rst_n, (s_axis_tvalid && s_axis_tready), !sts.div_busy, "command taken while dividing")

endmodule

/* tb/tb_zoom_about_point_controller.sv */
`timescale 1ns / 100ps
// self-checking testbench for the zoom-about-point controller: zoom commands in, results checked
module tb_zoom_about_point_controller;

    localparam int ZOOM_LIMIT   = zap_pkg::MAX_ZOOM_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LINES = 100;

    // opcodes with no operation behind them
    localparam logic [zap_pkg::OPC_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [zap_pkg::OPC_W-1:0] OP_SPARE_HI = 3'd7;

    localparam longint OFS_MAX = longint'(2147483647);
    localparam longint OFS_MIN = -OFS_MAX - 1;

    typedef struct {
        logic [zap_pkg::OUT_LVL_W-1:0]    level;
        logic signed [zap_pkg::OFS_W-1:0] x_ofs;
        logic signed [zap_pkg::OFS_W-1:0] y_ofs;
        logic                             sat;
    } view_t;

    class zoom_tracker;
        int                       level;
        int                       x_ofs;
        int                       y_ofs;
        logic [zap_pkg::VH_W-1:0] height;
        view_t                    views[$];
        int                       commands;
        int                       results;
        int                       sat_count;
        int                       errors;

        function new();
            level     = 1;
            x_ofs     = 0;
            y_ofs     = 0;
            height    = zap_pkg::VIEW_HEIGHT_RST;
            commands  = 0;
            results   = 0;
            sat_count = 0;
            errors    = 0;
        endfunction

        task report(string what);
            if (errors < REPORT_LINES)
            begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        // next rung up the ladder -max .. -4, -2, 1, 2, 4 .. max
        function int ladder_up(int lv);
            int p;
            if (lv >= ZOOM_LIMIT)
            begin
                return lv;
            end
            if (lv >= 1)
            begin
                p = 2;
                while (p <= lv)
                begin
                    p = p * 2;
                end
                return (p < ZOOM_LIMIT) ? p : ZOOM_LIMIT;
            end
            if (lv >= -2)
            begin
                return 1;
            end
            if (-lv > ZOOM_LIMIT)
            begin
                return -ZOOM_LIMIT;
            end
            p = 2;
            while (p * 2 < -lv)
            begin
                p = p * 2;
            end
            return -p;
        endfunction

        function int ladder_down(int lv);
            int p;
            if (lv <= -ZOOM_LIMIT)
            begin
                return lv;
            end
            if (lv > 1)
            begin
                if (lv > ZOOM_LIMIT)
                begin
                    return ZOOM_LIMIT;
                end
                p = 1;
                while (p * 2 < lv)
                begin
                    p = p * 2;
                end
                return p;
            end
            if (lv >= -1)
            begin
                return -2;
            end
            p = 2;
            while (p <= -lv)
            begin
                p = p * 2;
            end
            return (p < ZOOM_LIMIT) ? -p : -ZOOM_LIMIT;
        endfunction

        function int pick_level(logic [zap_pkg::OPC_W-1:0] op,
                                logic signed [zap_pkg::REQ_W-1:0] req);
            int lv;
            lv = level;
            case (op)
                zap_pkg::OP_STEP_UP:
                begin
                    if (lv < ZOOM_LIMIT)
                    begin
                        lv++;
                        if (lv == 0 || lv == -1)
                        begin
                            lv = 1;
                        end
                    end
                end
                zap_pkg::OP_STEP_DOWN:
                begin
                    if (lv > -ZOOM_LIMIT)
                    begin
                        lv--;
                        if (lv == 0 || lv == -1)
                        begin
                            lv = -2;
                        end
                    end
                end
                zap_pkg::OP_DOUBLE:
                begin
                    lv = ladder_up(lv);
                end
                zap_pkg::OP_HALVE:
                begin
                    lv = ladder_down(lv);
                end
                zap_pkg::OP_DIRECT:
                begin
                    lv = req;
                    if (lv > ZOOM_LIMIT)
                    begin
                        lv = ZOOM_LIMIT;
                    end
                    if (lv < -ZOOM_LIMIT)
                    begin
                        lv = -ZOOM_LIMIT;
                    end
                    if (lv == 0 || lv == -1)
                    begin
                        lv = 1;
                    end
                end
                default:
                begin
                end
            endcase
            return lv;
        endfunction

        function void scale_of(int lv, output longint num, output longint den);
            if (lv < 0)
            begin
                num = 1;
                den = -lv;
            end
            else
            begin
                num = lv;
                den = 1;
            end
        endfunction

        // c - ceil((c - p) * mul / dv), clipped to 32 bits
        function int shift_anchor(longint c, int p, longint mul, longint dv, inout bit sat);
            longint n;
            longint q;
            longint r;
            n = (c - longint'(p)) * mul;
            q = n / dv;
            if (n > 0 && n % dv != 0)
            begin
                q = q + 1;
            end
            r = c - q;
            if (r > OFS_MAX)
            begin
                sat = 1'b1;
                return int'(OFS_MAX);
            end
            if (r < OFS_MIN)
            begin
                sat = 1'b1;
                return int'(OFS_MIN);
            end
            return int'(r);
        endfunction

        function void note_command(logic [zap_pkg::IN_DATA_W-1:0] tdata,
                                   logic [zap_pkg::IN_USER_W-1:0] tuser);
            logic signed [zap_pkg::CUR_W-1:0] cx_raw;
            logic signed [zap_pkg::CUR_W-1:0] cy_raw;
            logic signed [zap_pkg::REQ_W-1:0] req;
            longint                           cx;
            longint                           cy;
            longint                           on;
            longint                           od;
            longint                           nn;
            longint                           nd;
            int                               new_lv;
            bit                               sat;
            view_t                            v;
            cx_raw = tdata[zap_pkg::CUR_W-1:0];
            cy_raw = tdata[2*zap_pkg::CUR_W-1:zap_pkg::CUR_W];
            req    = tdata[zap_pkg::IN_DATA_W-1:2*zap_pkg::CUR_W];
            cx     = cx_raw;
            // y flip: view origin top-left, image origin bottom-left
            cy     = longint'(height) - 1 - longint'(cy_raw);
            new_lv = pick_level(tuser[zap_pkg::OPC_W-1:0], req);
            scale_of(level, on, od);
            scale_of(new_lv, nn, nd);
            sat    = 1'b0;
            x_ofs  = shift_anchor(cx, x_ofs, nn * od, nd * on, sat);
            y_ofs  = shift_anchor(cy, y_ofs, nn * od, nd * on, sat);
            level  = new_lv;
            v.level = zap_pkg::OUT_LVL_W'(new_lv);
            v.x_ofs = x_ofs;
            v.y_ofs = y_ofs;
            v.sat   = sat;
            views.push_back(v);
            commands++;
            if (sat)
            begin
                sat_count++;
            end
        endfunction

        task check_view(logic [zap_pkg::OUT_DATA_W-1:0] tdata,
                        logic [zap_pkg::OUT_USER_W-1:0] tuser);
            view_t want;
            string bad;
            results++;
            if (views.size() == 0)
            begin
                report($sformatf("result %h/%h with no command outstanding", tdata, tuser));
                return;
            end
            want = views.pop_front();
            bad  = "";
            if (tdata[zap_pkg::OUT_LVL_W-1:0] !== want.level)
            begin
                bad = {bad, $sformatf(" level %0d want %0d",
                                      $signed(tdata[zap_pkg::OUT_LVL_W-1:0]),
                                      $signed(want.level))};
            end
            if (tdata[zap_pkg::OUT_LVL_W +: zap_pkg::OFS_W] !== want.x_ofs)
            begin
                bad = {bad, $sformatf(" x %0d want %0d",
                                      $signed(tdata[zap_pkg::OUT_LVL_W +: zap_pkg::OFS_W]),
                                      want.x_ofs)};
            end
            if (tdata[zap_pkg::OUT_LVL_W + zap_pkg::OFS_W +: zap_pkg::OFS_W] !== want.y_ofs)
            begin
                bad = {bad, $sformatf(" y %0d want %0d",
                    $signed(tdata[zap_pkg::OUT_LVL_W + zap_pkg::OFS_W +: zap_pkg::OFS_W]),
                    want.y_ofs)};
            end
            if (tuser[0] !== want.sat)
            begin
                bad = {bad, $sformatf(" saturated %b want %b", tuser[0], want.sat)};
            end
            if (bad != "")
            begin
                report($sformatf("result %0d:%s", results, bad));
            end
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [zap_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [zap_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [zap_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [zap_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                           cfg_we;
    logic [zap_pkg::VH_W-1:0]       cfg_wdata;

    zoom_tracker tracker;
    bit          steady;
    int          height_writes;

    zoom_about_point_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 4);
        end
        if (roll < 97)
        begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [zap_pkg::CUR_W-1:0] rand_cursor();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3, 4, 5: return zap_pkg::CUR_W'(int'($urandom_range(0, 400)) - 200);
            default: return zap_pkg::CUR_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [zap_pkg::REQ_W-1:0] rand_req();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
        begin
            return zap_pkg::REQ_W'(int'($urandom_range(0, 40)) - 20);
        end
        if (roll < 9)
        begin
            return zap_pkg::REQ_W'(int'($urandom_range(0, 128)) - 64);
        end
        return zap_pkg::REQ_W'($urandom);
    endfunction

    function automatic logic [zap_pkg::OPC_W-1:0] rand_op();
        int roll;
        roll = $urandom_range(0, 31);
        if (roll < 2)
        begin
            return zap_pkg::OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return zap_pkg::OPC_W'(roll % 5);
    endfunction

    // entered and left at a falling edge; tvalid stays high when the next command follows at once
    task send_cmd(input logic [zap_pkg::OPC_W-1:0] op,
                  input logic signed [zap_pkg::CUR_W-1:0] cx,
                  input logic signed [zap_pkg::CUR_W-1:0] cy,
                  input logic signed [zap_pkg::REQ_W-1:0] req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req, cy, cx};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task write_height(input logic [zap_pkg::VH_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (tracker.views.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_we         <= 1'b1;
        cfg_wdata      <= value;
        tracker.height = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        height_writes++;
    endtask

    task run_directed();
        send_cmd(zap_pkg::OP_STEP_UP, 0, 0, 0);
        send_cmd(zap_pkg::OP_DIRECT, 32767, -32768, 16);
        send_cmd(zap_pkg::OP_STEP_UP, -32768, 32767, 0);     // already at the top
        send_cmd(zap_pkg::OP_DOUBLE, 100, 200, 0);
        send_cmd(zap_pkg::OP_HALVE, 1, -1, 0);
        send_cmd(zap_pkg::OP_HALVE, -5, 7, 0);
        send_cmd(zap_pkg::OP_HALVE, 300, -300, 0);
        send_cmd(zap_pkg::OP_HALVE, 0, 0, 0);
        send_cmd(zap_pkg::OP_HALVE, 12, 34, 0);              // 1 down to -2
        send_cmd(zap_pkg::OP_STEP_UP, 5, 5, 0);              // -2 up skips 0 and -1
        send_cmd(zap_pkg::OP_STEP_DOWN, -7, 3, 0);
        send_cmd(zap_pkg::OP_STEP_DOWN, 9, 9, 0);
        send_cmd(zap_pkg::OP_DOUBLE, 1000, -1000, 0);
        send_cmd(zap_pkg::OP_HALVE, 77, 88, 0);
        send_cmd(zap_pkg::OP_DIRECT, -32768, 32767, -64);    // clamped to the bottom
        send_cmd(zap_pkg::OP_STEP_DOWN, 0, 0, 0);
        send_cmd(zap_pkg::OP_HALVE, 1, 1, 0);
        send_cmd(zap_pkg::OP_DOUBLE, 2, 2, 0);
        send_cmd(zap_pkg::OP_DIRECT, 3, 3, 0);
        send_cmd(zap_pkg::OP_DIRECT, 4, 4, -1);
        send_cmd(zap_pkg::OP_DIRECT, 5, 5, -128);
        send_cmd(zap_pkg::OP_DIRECT, 6, 6, 127);
        send_cmd(OP_SPARE_LO, 8, 8, 3);
        send_cmd(OP_SPARE_HI, -9, -9, -3);
    endtask

    task run_mixed(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_cmd(rand_op(), rand_cursor(), rand_cursor(), rand_req());
        end
    endtask

    // zoom out at one corner, back in at the opposite one: the offset walks by about
    // 255 * 65535 per pair until both axes clip, x upwards and y downwards
    task run_sweep(input int pairs);
        for (int i = 0; i < pairs; i++)
        begin
            steady = (i < 40);
            send_cmd(zap_pkg::OP_DIRECT,
                     zap_pkg::CUR_W'(32767 - int'($urandom_range(0, 15))),
                     zap_pkg::CUR_W'(32767 - int'($urandom_range(0, 15))),
                     zap_pkg::REQ_W'(-int'($urandom_range(ZOOM_LIMIT, 64))));
            send_cmd(zap_pkg::OP_DIRECT,
                     zap_pkg::CUR_W'(-32768 + int'($urandom_range(0, 15))),
                     zap_pkg::CUR_W'(-32768 + int'($urandom_range(0, 15))),
                     zap_pkg::REQ_W'($urandom_range(ZOOM_LIMIT, 64)));
        end
        steady = 1'b0;
    endtask

    // receiver: one cycle ready, then a stall of random length
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.note_command(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_view(m_axis_tdata, m_axis_tuser);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("stalled for %0d cycles with no transfer", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        steady        = 1'b0;
        height_writes = 0;
        tracker       = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        write_height(16'd1);
        steady = 1'b1;
        run_mixed(60);
        steady = 1'b0;
        write_height(16'hFFFF);
        run_sweep(150);
        run_mixed(30);
        // zero height: the flip still applies
        write_height(16'd0);
        run_mixed(60);
        write_height(zap_pkg::VH_W'($urandom_range(2, 65534)));
        run_mixed(60);

        s_axis_tvalid <= 1'b0;
        while (tracker.views.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d commands and %0d results, %0d of them with a clipped offset",
                 tracker.commands, tracker.results, tracker.sat_count);
        $display("view height written %0d times, last %0d; mismatches: %0d",
                 height_writes, tracker.height, tracker.errors);
        if (tracker.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
